// ===== sv/max_tracking_stack_assert.svh =====
// Assertion macros for the max tracking stack.
`ifndef MAX_TRACKING_STACK_ASSERT_SVH
`define MAX_TRACKING_STACK_ASSERT_SVH

// Property that must hold in the same cycle as its condition.
`define MTS_ASSERT_NOW(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("max_tracking_stack: same-cycle check failed");

// Property that must hold in the cycle after its condition.
`define MTS_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("max_tracking_stack: next-cycle check failed");

`endif

// ===== sv/mts_pkg.sv =====
`timescale 1ns / 1ps
package mts_pkg;

    // Number of entries in each stack.
    localparam int DEPTH   = 64;
    localparam int DATA_W  = 32;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DEPTH_W = 7;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [CNT_W-1:0]         count_t;

    // Operation codes of the mode field.
    typedef enum logic {
        MODE_PUSH = 1'b0,
        MODE_POP  = 1'b1
    } mode_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Shift control shared by every cell of one chain.
    typedef struct packed {
        logic push;
        logic pop;
    } shift_ctrl_t;

endpackage

// ===== sv/mts_cell.sv =====
`timescale 1ns / 1ps
module mts_cell
    import mts_pkg::*;
(
    input  logic        clk,
    input  shift_ctrl_t ctrl,
    input  data_t       up_data,
    input  data_t       down_data,
    output data_t       entry
);

    data_t entry_reg;
    data_t entry_next;

    // A push takes the entry of the neighbor nearer the top; a pop takes the one below.
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.push)
        begin
            entry_next = up_data;
        end
        else if (ctrl.pop)
        begin
            entry_next = down_data;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== sv/max_tracking_stack.sv =====
`timescale 1ns / 1ps
// Bounded stack of signed 32-bit values that also tracks its running maximum. Each
// transaction is a push or a pop, accepted when start is high; busy is always low, so
// one transaction can be taken in every clock cycle. Both stacks are rows of shift
// cells with the top in the first cell. The result appears on the cycle after
// acceptance, marked by done for exactly one cycle. The receiver cannot stall and
// must take each result as it appears. A push onto a full stack or a pop from an
// empty one changes nothing and is flagged in status; top_value and max_value read
// as zero while the stack is empty.
module max_tracking_stack
    import mts_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      mode,
    input  logic signed [DATA_W-1:0]  value,
    output logic                      done,
    output logic [1:0]                status,
    output logic signed [DATA_W-1:0]  top_value,
    output logic signed [DATA_W-1:0]  max_value,
    output logic [DEPTH_W-1:0]        depth
);

`include "max_tracking_stack_assert.svh"

    count_t      value_count_reg;
    count_t      value_count_next;
    count_t      max_count_reg;
    count_t      max_count_next;
    logic        done_reg;
    status_t     status_reg;
    status_t     status_next;

    shift_ctrl_t value_ctrl;
    shift_ctrl_t max_ctrl;
    data_t       value_cells [DEPTH];
    data_t       max_cells   [DEPTH];

    logic        is_push;
    logic        is_pop;
    logic        push_ok;
    logic        pop_ok;

    // Decode the transaction and the conditions that gate each stack.
    always_comb
    begin
        is_push = start && (mode == MODE_PUSH);
        is_pop  = start && (mode == MODE_POP);
        push_ok = is_push && (value_count_reg < CNT_W'(DEPTH));
        pop_ok  = is_pop && (value_count_reg != '0);

        value_ctrl.push = push_ok;
        value_ctrl.pop  = pop_ok;

        max_ctrl.push = push_ok && (max_count_reg < CNT_W'(DEPTH)) &&
                        ((value_count_reg == '0) || (max_count_reg == '0) ||
                         (value >= max_cells[0]));
        max_ctrl.pop  = pop_ok && (max_count_reg != '0) &&
                        (value_cells[0] == max_cells[0]);

        value_count_next = value_count_reg;
        if (value_ctrl.push)
        begin
            value_count_next = value_count_reg + count_t'(1);
        end
        else if (value_ctrl.pop)
        begin
            value_count_next = value_count_reg - count_t'(1);
        end

        max_count_next = max_count_reg;
        if (max_ctrl.push)
        begin
            max_count_next = max_count_reg + count_t'(1);
        end
        else if (max_ctrl.pop)
        begin
            max_count_next = max_count_reg - count_t'(1);
        end

        status_next = ST_DONE;
        if (is_push && !push_ok)
        begin
            status_next = ST_FULL;
        end
        else if (is_pop && !pop_ok)
        begin
            status_next = ST_EMPTY;
        end
    end

    // Rows of cells for the values and the maxima; the first cell holds the top.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cells
        data_t value_up;
        data_t value_down;
        data_t max_up;
        data_t max_down;

        if (i == 0)
        begin : g_first
            assign value_up = value;
            assign max_up   = value;
        end
        else
        begin : g_inner
            assign value_up = value_cells[i-1];
            assign max_up   = max_cells[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign value_down = '0;
            assign max_down   = '0;
        end
        else
        begin : g_lower
            assign value_down = value_cells[i+1];
            assign max_down   = max_cells[i+1];
        end

        mts_cell u_value_cell (
            .clk       (clk),
            .ctrl      (value_ctrl),
            .up_data   (value_up),
            .down_data (value_down),
            .entry     (value_cells[i])
        );

        mts_cell u_max_cell (
            .clk       (clk),
            .ctrl      (max_ctrl),
            .up_data   (max_up),
            .down_data (max_down),
            .entry     (max_cells[i])
        );
    end

    // Counts, result strobe and status.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_count_reg <= '0;
            max_count_reg   <= '0;
            done_reg        <= 1'b0;
            status_reg      <= ST_DONE;
        end
        else
        begin
            value_count_reg <= value_count_next;
            max_count_reg   <= max_count_next;
            done_reg        <= start;
            if (start)
            begin
                status_reg <= status_next;
            end
        end
    end

    // The result shows the state held after the last transaction.
    assign busy      = 1'b0;
    assign done      = done_reg;
    assign status    = status_reg;
    assign top_value = (value_count_reg == '0) ? data_t'(0) : value_cells[0];
    assign max_value = ((value_count_reg == '0) || (max_count_reg == '0)) ?
                       data_t'(0) : max_cells[0];
    assign depth     = DEPTH_W'(value_count_reg);

    // The maxima stack never holds more entries than the value stack.
    `MTS_ASSERT_NOW(a_max_count_bound, 1'b1, max_count_reg <= value_count_reg)
    // The top value never exceeds the reported maximum.
    `MTS_ASSERT_NOW(a_top_below_max, done, top_value <= max_value)
    // Every accepted transaction gives exactly one result in the next cycle.
    `MTS_ASSERT_NEXT(a_result_follows, start && !busy, done)
    // A push onto a stack that is not full raises the depth by one.
    `MTS_ASSERT_NEXT(a_push_grows, push_ok,
        value_count_reg == $past(value_count_reg) + count_t'(1))

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import mts_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_LIMIT = 10;
    localparam int FIFO_DEPTH = 8;

    // One predicted result of a push or pop.
    typedef struct {
        status_t status;
        data_t   top;
        data_t   peak;
        logic [DEPTH_W-1:0] fill;
    } stack_view_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic mode;
    logic signed [DATA_W-1:0] value;
    logic done;
    logic [1:0] status;
    logic signed [DATA_W-1:0] top_value;
    logic signed [DATA_W-1:0] max_value;
    logic [DEPTH_W-1:0] depth;

    // Shadow copy of both stacks.
    data_t stack_vals [DEPTH];
    data_t stack_peaks [DEPTH];
    int unsigned val_count;
    int unsigned peak_count;

    // Predicted results in order; the sender writes, the checker reads.
    stack_view_t result_fifo [FIFO_DEPTH];
    logic [2:0] fifo_wr_ptr;
    logic [2:0] fifo_rd_ptr;
    int unsigned mismatch_count;
    int unsigned cycle_count;
    int unsigned sender_idle_pct;

    max_tracking_stack dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .mode      (mode),
        .value     (value),
        .done      (done),
        .status    (status),
        .top_value (top_value),
        .max_value (max_value),
        .depth     (depth)
    );

    // Free-running clock with a 2 ns period.
    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Applies one operation to the shadow stacks and returns the state it leaves.
    function automatic stack_view_t apply_stack_op(mode_t op, data_t val);
        stack_view_t view;
        bit was_empty;
        view.status = ST_DONE;
        if (op == MODE_PUSH)
        begin
            if (val_count >= DEPTH)
            begin
                view.status = ST_FULL;
            end
            else
            begin
                was_empty = (val_count == 0);
                stack_vals[val_count] = val;
                val_count++;
                if ((was_empty || peak_count == 0 || val >= stack_peaks[peak_count - 1])
                    && peak_count < DEPTH)
                begin
                    stack_peaks[peak_count] = val;
                    peak_count++;
                end
            end
        end
        else
        begin
            if (val_count == 0)
            begin
                view.status = ST_EMPTY;
            end
            else
            begin
                // A popped value equal to the recorded maximum takes that maximum along.
                if (peak_count > 0 && stack_vals[val_count - 1] == stack_peaks[peak_count - 1])
                begin
                    peak_count--;
                end
                val_count--;
            end
        end
        view.top  = (val_count == 0) ? '0 : stack_vals[val_count - 1];
        view.peak = (val_count == 0 || peak_count == 0) ? '0 : stack_peaks[peak_count - 1];
        view.fill = val_count[DEPTH_W-1:0];
        return view;
    endfunction

    // Sends one transaction, with random idle cycles ahead of it.
    task automatic send_op(mode_t op, data_t val);
        stack_view_t view;
        @(negedge clk);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        mode  <= op;
        value <= val;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        view = apply_stack_op(op, val);
        result_fifo[fifo_wr_ptr] = view;
        fifo_wr_ptr = fifo_wr_ptr + 3'd1;
    endtask

    // Stops sending and waits until every predicted result has come back.
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (fifo_wr_ptr != fifo_rd_ptr)
        begin
            @(posedge clk);
        end
    endtask

    // Draws a value: often from a narrow range so that duplicate maxima are common.
    function automatic data_t pick_value();
        data_t val;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: val = $signed($urandom_range(0, 15)) - 8;
            4:
            begin
                case ($urandom_range(0, 3))
                    0: val = 32'sh7fffffff;
                    1: val = 32'sh80000000;
                    2: val = -1;
                    default: val = 0;
                endcase
            end
            default: val = $urandom;
        endcase
        return val;
    endfunction

    // Pop from an empty stack, push the most negative value, pop it, pop again.
    task automatic test_empty_stack();
        send_op(MODE_POP, 32'sd0);
        send_op(MODE_PUSH, 32'sh80000000);
        send_op(MODE_POP, 32'sh7fffffff);
        send_op(MODE_POP, -1);
    endtask

    // Extreme values, including a push equal to the maximum.
    task automatic test_extremes();
        send_op(MODE_PUSH, 32'sh7fffffff);
        send_op(MODE_PUSH, 32'sh80000000);
        send_op(MODE_PUSH, -1);
        send_op(MODE_PUSH, 32'sd0);
        send_op(MODE_PUSH, 32'sh7fffffff);
        send_op(MODE_POP, 32'sd0);
        send_op(MODE_POP, 32'sd0);
        send_op(MODE_POP, 32'sd0);
    endtask

    // Duplicate maxima must survive the pop of one copy.
    task automatic test_duplicate_max();
        int unsigned i;
        send_op(MODE_PUSH, 32'sd5);
        send_op(MODE_PUSH, 32'sd5);
        send_op(MODE_PUSH, 32'sd3);
        send_op(MODE_PUSH, 32'sd5);
        send_op(MODE_PUSH, 32'sd7);
        for (i = 0; i < 7; i++)
        begin
            send_op(MODE_POP, 32'sd0);
        end
    endtask

    // Random pushes and pops; the push bias changes in stretches so the stack
    // swings between empty and full.
    task automatic test_random_traffic(int unsigned count);
        int unsigned i;
        int unsigned push_pct;
        push_pct = 50;
        for (i = 0; i < count; i++)
        begin
            if (i % 80 == 0)
            begin
                case ($urandom_range(0, 4))
                    0: push_pct = 25;
                    1: push_pct = 50;
                    2: push_pct = 70;
                    default: push_pct = 95;
                endcase
            end
            if ($urandom_range(0, 99) < push_pct)
            begin
                send_op(MODE_PUSH, pick_value());
            end
            else
            begin
                send_op(MODE_POP, $urandom);
            end
        end
    endtask

    // Compares each result with the oldest prediction.
    always @(posedge clk)
    begin
        stack_view_t want;
        if (rst_n && done)
        begin
            if (fifo_wr_ptr == fifo_rd_ptr)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                begin
                    $display("unexpected result: status %0d top %0d max %0d depth %0d",
                             status, top_value, max_value, depth);
                end
            end
            else
            begin
                want = result_fifo[fifo_rd_ptr];
                fifo_rd_ptr = fifo_rd_ptr + 3'd1;
                if (status !== want.status || top_value !== want.top
                    || max_value !== want.peak || depth !== want.fill)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                    begin
                        $display("expected status %0d top %0d max %0d depth %0d",
                                 want.status, want.top, want.peak, want.fill);
                        $display("  actual status %0d top %0d max %0d depth %0d",
                                 status, top_value, max_value, depth);
                    end
                end
            end
        end
    end

    // Ends a run that hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("max_tracking_stack: mismatch");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        mode = MODE_PUSH;
        value = '0;
        val_count = 0;
        peak_count = 0;
        fifo_wr_ptr = '0;
        fifo_rd_ptr = '0;
        mismatch_count = 0;
        cycle_count = 0;
        sender_idle_pct = 27;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_stack();
        test_extremes();
        test_duplicate_max();
        test_random_traffic(560);
        drain_results();

        sender_idle_pct = 58;
        test_random_traffic(560);

        sender_idle_pct = 0;
        test_random_traffic(560);
        drain_results();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("max_tracking_stack: match");
        end
        else
        begin
            $display("max_tracking_stack: mismatch");
        end
        $finish;
    end

endmodule
